### src/abrf_pkg.sv
package abrf_pkg;

    localparam int unsigned FRAME_WIDTH_DEF  = 512;
    localparam int unsigned FRAME_HEIGHT_DEF = 512;
    localparam logic [7:0]  FULL_SCALE       = 8'd255;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL,
        ST_DRAIN,
        ST_READ,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    // floor((pa + pb) / 255), exact for sums up to 65279
    function automatic logic [7:0] blend_div(input logic [15:0] pa, input logic [15:0] pb);
        logic [16:0] sum;
        logic [16:0] t;
        sum = {1'b0, pa} + {1'b0, pb};
        t   = sum + 17'd1 + (sum >> 8);
        return t[15:8];
    endfunction

endpackage

### src/alpha_blend_rect_fill_top.sv
// Channel  Dir  Handshake                         Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready   tdata: command geometry+color, tuser: opcode
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready   tdata: pixel RGBA, tuser: clipped
//
// Clear: one frame store write per cycle across the whole frame store.
// Fill: one read-modify-write per visible pixel
//   through the single-port-pair frame store (read, multiply, divide-and-write).
// Synchronous active-low reset clears control only; frame store is undefined until cleared.
// A new request is taken while the previous result waits in the output register.
module alpha_blend_rect_fill_top
    import abrf_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // left_x[8:0] top_y[17:9] rect_width[27:18] rect_height[37:28]
    // red[45:38] green[53:46] blue[61:54] opacity[69:62], zero pad
    input  logic [71:0] i_s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_red[7:0] pixel_green[15:8] pixel_blue[23:16] pixel_alpha[31:24]
    output logic [31:0] o_m_axis_tdata,
    // clipped[0]
    output logic [0:0]  o_m_axis_tuser
);

    localparam int unsigned DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW     = ($clog2(FRAME_WIDTH + 1) > 11) ?
                                     $clog2(FRAME_WIDTH + 1) : 11;
    localparam int unsigned YW     = ($clog2(FRAME_HEIGHT + 1) > 11) ?
                                     $clog2(FRAME_HEIGHT + 1) : 11;

    t_state r_state, n_state;

    logic [31:0] mem [DEPTH];

    logic [XW-1:0]     r_x, r_x0, r_xe;
    logic [YW-1:0]     r_y, r_ye;
    logic [ADDR_W-1:0] r_addr, r_row_addr;
    logic [7:0]        r_src [3];
    logic [7:0]        r_alpha;
    logic [31:0]       r_pix;
    logic              r_clip;

    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [31:0]       r_rd_data;
    logic              r_s2_valid;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [7:0]        r_s2_alpha;
    logic [15:0]       r_s2_pa [3];
    logic [15:0]       r_s2_pb [3];

    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_clip;

    logic              s_fire, m_fire, out_load;
    t_op               in_op;
    logic [8:0]        in_lx, in_ty;
    logic [9:0]        in_w, in_h;
    logic [XW-1:0]     in_xe_raw, in_xe;
    logic [YW-1:0]     in_ye_raw, in_ye;
    logic              in_pt_ok, in_empty, in_clip;
    logic [ADDR_W-1:0] in_addr;
    logic              x_last, y_last;
    logic              rd_en, mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [7:0]        blend_ch [3];

    assign in_op  = t_op'(i_s_axis_tuser);
    assign in_lx  = i_s_axis_tdata[8:0];
    assign in_ty  = i_s_axis_tdata[17:9];
    assign in_w   = i_s_axis_tdata[27:18];
    assign in_h   = i_s_axis_tdata[37:28];

    assign in_xe_raw = XW'(in_lx) + XW'(in_w);
    assign in_ye_raw = YW'(in_ty) + YW'(in_h);
    assign in_xe     = (in_xe_raw > XW'(FRAME_WIDTH)) ? XW'(FRAME_WIDTH) : in_xe_raw;
    assign in_ye     = (in_ye_raw > YW'(FRAME_HEIGHT)) ? YW'(FRAME_HEIGHT) : in_ye_raw;
    assign in_pt_ok  = (XW'(in_lx) < XW'(FRAME_WIDTH)) && (YW'(in_ty) < YW'(FRAME_HEIGHT));
    assign in_empty  = (in_w == 10'd0) || (in_h == 10'd0);
    assign in_clip   = (in_xe_raw > XW'(FRAME_WIDTH)) || (in_ye_raw > YW'(FRAME_HEIGHT));
    assign in_addr   = ADDR_W'(32'(in_ty) * 32'(FRAME_WIDTH) + 32'(in_lx));

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign m_fire   = r_out_valid && i_m_axis_tready;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    assign x_last = (r_x == r_xe - XW'(1));
    assign y_last = (r_y == r_ye - YW'(1));

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_clip;

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (in_op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_FILL:  n_state = (!in_empty && in_pt_ok) ? ST_FILL : ST_DONE;
                        OP_READ:  n_state = in_pt_ok ? ST_READ : ST_DONE;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_addr == ADDR_W'(DEPTH - 1)) n_state = ST_DONE;
            end
            ST_FILL: begin
                rd_en = 1'b1;
                if (x_last && y_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) n_state = ST_DONE;
            end
            ST_READ: begin
                rd_en   = 1'b1;
                n_state = ST_RDWAIT;
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            blend_ch[k] = blend_div(r_s2_pa[k], r_s2_pb[k]);
        end
    end

    assign mem_we    = (r_state == ST_CLEAR) || r_s2_valid;
    assign mem_waddr = (r_state == ST_CLEAR) ? r_addr : r_s2_addr;
    assign mem_wdata = (r_state == ST_CLEAR) ? {r_alpha, r_src[2], r_src[1], r_src[0]}
                                             : {r_s2_alpha, blend_ch[2], blend_ch[1],
                                                blend_ch[0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == ST_FILL);
            r_s2_valid <= r_s1_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_x        <= XW'(in_lx);
            r_x0       <= XW'(in_lx);
            r_y        <= YW'(in_ty);
            r_xe       <= in_xe;
            r_ye       <= in_ye;
            r_addr     <= (in_op == OP_CLEAR) ? '0 : in_addr;
            r_row_addr <= in_addr;
            r_src[0]   <= i_s_axis_tdata[45:38];
            r_src[1]   <= i_s_axis_tdata[53:46];
            r_src[2]   <= i_s_axis_tdata[61:54];
            r_alpha    <= i_s_axis_tdata[69:62];
            r_pix      <= '0;
            case (in_op)
                OP_FILL: r_clip <= !in_empty && in_clip;
                OP_READ: r_clip <= !in_pt_ok;
                default: r_clip <= 1'b0;
            endcase
        end else if (r_state == ST_CLEAR) begin
            r_addr <= r_addr + ADDR_W'(1);
        end else if (r_state == ST_FILL) begin
            if (x_last) begin
                r_x        <= r_x0;
                r_y        <= r_y + YW'(1);
                r_row_addr <= r_row_addr + ADDR_W'(FRAME_WIDTH);
                r_addr     <= r_row_addr + ADDR_W'(FRAME_WIDTH);
            end else begin
                r_x    <= r_x + XW'(1);
                r_addr <= r_addr + ADDR_W'(1);
            end
        end else if (r_state == ST_RDWAIT) begin
            r_pix <= r_rd_data;
        end

        r_s1_addr  <= r_addr;
        r_s2_addr  <= r_s1_addr;
        r_s2_alpha <= r_rd_data[31:24];
        for (int k = 0; k < 3; k++) begin
            r_s2_pa[k] <= {8'd0, r_rd_data[8*k +: 8]} * {8'd0, FULL_SCALE - r_alpha};
            r_s2_pb[k] <= {8'd0, r_src[k]} * {8'd0, r_alpha};
        end

        if (out_load) begin
            r_out_data <= r_pix;
            r_out_clip <= r_clip;
        end
    end

`ifndef SYNTHESIS
    a_clear_no_blend_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_s2_valid)
        else $error("blend write overlaps clear sweep");

    a_accept_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |-> (!r_s1_valid && !r_s2_valid))
        else $error("request accepted with blend pipeline busy");

    a_fill_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> ((r_x < r_xe) && (r_y < r_ye)))
        else $error("fill scan outside clipped rectangle");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_s1_valid && !r_s2_valid))
        else $error("result issued before write-back finished");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import abrf_pkg::*;

    localparam int FW = FRAME_WIDTH_DEF;
    localparam int FH = FRAME_HEIGHT_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 75;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_TAIL = 15;

    typedef struct packed {
        logic [1:0] op;
        logic [8:0] lx;
        logic [8:0] ty;
        logic [9:0] w;
        logic [9:0] h;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_draw_cmd;

    typedef struct packed {
        logic [31:0] pix;
        logic        clip;
    } t_pixel_rsp;

    typedef struct packed {
        t_draw_cmd  cmd;
        logic       typed;
        t_pixel_rsp rsp;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    bit [31:0]  frame_shadow [FW*FH];
    t_pixel_rsp expected_pixels [$];
    t_dir_row   directed [$];
    int         error_count = 0;
    int         rsp_count = 0;
    int         req_accepted = 0;
    int         total_items = 0;

    alpha_blend_rect_fill_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [7:0] mix_channel(bit [7:0] old, bit [7:0] src, bit [7:0] a);
        int unsigned v;
        v = (int'(old) * (int'(FULL_SCALE) - int'(a)) + int'(src) * int'(a))
            / int'(FULL_SCALE);
        return v[7:0];
    endfunction

    function automatic t_pixel_rsp paint_command(t_draw_cmd c);
        t_pixel_rsp rsp;
        int xe;
        int ye;
        int idx;
        bit [31:0] old;
        rsp = '0;
        case (c.op)
            OP_CLEAR: begin
                for (int i = 0; i < FW * FH; i++)
                    frame_shadow[i] = {c.opacity, c.blue, c.green, c.red};
            end
            OP_FILL: begin
                if (c.w != 0 && c.h != 0) begin
                    xe = int'(c.lx) + int'(c.w);
                    ye = int'(c.ty) + int'(c.h);
                    if (xe > FW) begin
                        rsp.clip = 1'b1;
                        xe = FW;
                    end
                    if (ye > FH) begin
                        rsp.clip = 1'b1;
                        ye = FH;
                    end
                    for (int y = int'(c.ty); y < ye; y++) begin
                        for (int x = int'(c.lx); x < xe; x++) begin
                            idx = y * FW + x;
                            old = frame_shadow[idx];
                            frame_shadow[idx] = {old[31:24],
                                mix_channel(old[23:16], c.blue, c.opacity),
                                mix_channel(old[15:8], c.green, c.opacity),
                                mix_channel(old[7:0], c.red, c.opacity)};
                        end
                    end
                end
            end
            OP_READ: begin
                if (int'(c.lx) < FW && int'(c.ty) < FH)
                    rsp.pix = frame_shadow[int'(c.ty) * FW + int'(c.lx)];
                else
                    rsp.clip = 1'b1;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic t_dir_row mk_row(logic [1:0] op, int lx, int ty, int w, int h,
                                        int r, int g, int b, int a,
                                        bit typed, logic [31:0] pix, bit clip);
        t_dir_row row;
        row.cmd = '{op, lx[8:0], ty[8:0], w[9:0], h[9:0], r[7:0], g[7:0], b[7:0], a[7:0]};
        row.typed = typed;
        row.rsp = '{pix, clip};
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("response %0d: %s got %0d expected %0d", rsp_count, what, got, want);
        error_count++;
    endtask

    task automatic offer_request(t_draw_cmd c, bit typed, t_pixel_rsp typed_rsp);
        t_pixel_rsp predicted;
        if (req_accepted < total_items - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c.op;
        // opacity blue green red height width top left, from the top bits down
        i_s_axis_tdata  <= {2'b00, c.opacity, c.blue, c.green, c.red, c.h, c.w, c.ty, c.lx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = paint_command(c);
        expected_pixels.push_back(typed ? typed_rsp : predicted);
        req_accepted++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_pixel_rsp want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected response, tdata", int'(o_m_axis_tdata), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_m_axis_tdata[7:0] !== want.pix[7:0])
                    report_mismatch("pixel_red", int'(o_m_axis_tdata[7:0]),
                                    int'(want.pix[7:0]));
                if (o_m_axis_tdata[15:8] !== want.pix[15:8])
                    report_mismatch("pixel_green", int'(o_m_axis_tdata[15:8]),
                                    int'(want.pix[15:8]));
                if (o_m_axis_tdata[23:16] !== want.pix[23:16])
                    report_mismatch("pixel_blue", int'(o_m_axis_tdata[23:16]),
                                    int'(want.pix[23:16]));
                if (o_m_axis_tdata[31:24] !== want.pix[31:24])
                    report_mismatch("pixel_alpha", int'(o_m_axis_tdata[31:24]),
                                    int'(want.pix[31:24]));
                if (o_m_axis_tuser[0] !== want.clip)
                    report_mismatch("clipped", int'(o_m_axis_tuser[0]), int'(want.clip));
            end
            rsp_count++;
        end
    end

    // result side backpressure, with one long hold to fill the block up
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && total_items != 0 && req_accepted >= directed.size() + 10) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (req_accepted < total_items - QUIET_TAIL
                         && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        #(30_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_draw_cmd  c;
        t_pixel_rsp none;
        int clear_at;
        int mode;
        bit have_rect;
        int rect_x;
        int rect_y;
        int rect_w;
        int rect_h;

        none = '0;
        have_rect = 1'b0;
        rect_x = 0;
        rect_y = 0;
        rect_w = 0;
        rect_h = 0;

        // op, x, y, w, h, r, g, b, a, typed, pixel, clipped
        directed.push_back(mk_row(OP_CLEAR, 0, 0, 0, 0, 12, 34, 56, 78, 1, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h4E38220C, 0));
        directed.push_back(mk_row(OP_READ, 511, 511, 1023, 1023, 255, 255, 255, 255,
                                  1, 32'h4E38220C, 0));
        directed.push_back(mk_row(OP_UNUSED, 511, 511, 1023, 1023, 255, 255, 255, 255,
                                  1, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 0, 0, 0, 5, 9, 9, 9, 200, 1, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 500, 500, 5, 0, 9, 9, 9, 200, 1, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 10, 10, 4, 4, 255, 255, 255, 0, 1, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 11, 11, 0, 0, 0, 0, 0, 0, 1, 32'h4E38220C, 0));
        directed.push_back(mk_row(OP_FILL, 10, 10, 2, 2, 200, 100, 50, 255, 1, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 10, 10, 0, 0, 0, 0, 0, 0, 1, 32'h4E3264C8, 0));
        directed.push_back(mk_row(OP_FILL, 20, 20, 3, 3, 255, 0, 128, 128, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 21, 22, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 511, 511, 512, 512, 1, 2, 3, 255, 1, 32'h0, 1));
        directed.push_back(mk_row(OP_READ, 511, 511, 0, 0, 0, 0, 0, 0, 1, 32'h4E030201, 0));
        directed.push_back(mk_row(OP_FILL, 0, 100, 512, 1, 170, 85, 240, 77, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 300, 0, 1, 512, 15, 240, 60, 180, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 500, 200, 20, 3, 33, 66, 99, 150, 1, 32'h0, 1));
        directed.push_back(mk_row(OP_FILL, 5, 505, 3, 10, 99, 66, 33, 60, 1, 32'h0, 1));
        directed.push_back(mk_row(OP_READ, 300, 100, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 511, 100, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 510, 201, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 511, 0, 1, 1, 255, 255, 255, 1, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 511, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_FILL, 0, 0, 1, 1, 0, 0, 0, 254, 0, 32'h0, 0));
        directed.push_back(mk_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0));
        total_items = directed.size() + RANDOM_ITEMS;
        clear_at = $urandom_range(30, 70);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            offer_request(directed[k].cmd, directed[k].typed, directed[k].rsp);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            c.lx      = 9'($urandom_range(0, 511));
            c.ty      = 9'($urandom_range(0, 511));
            c.w       = 10'($urandom_range(0, 512));
            c.h       = 10'($urandom_range(0, 512));
            c.red     = 8'($urandom_range(0, 255));
            c.green   = 8'($urandom_range(0, 255));
            c.blue    = 8'($urandom_range(0, 255));
            c.opacity = 8'($urandom_range(0, 255));
            mode = $urandom_range(0, 99);
            if (n == clear_at)
                c.op = OP_CLEAR;
            else if (mode < 5)
                c.op = OP_UNUSED;
            else if (mode < 50)
                c.op = OP_READ;
            else
                c.op = OP_FILL;

            if (c.op == OP_FILL) begin
                mode = $urandom_range(0, 9);
                if (mode <= 5) begin
                    c.w = 10'($urandom_range(0, 24));
                    c.h = 10'($urandom_range(0, 24));
                end else if (mode <= 7) begin
                    c.lx = 9'($urandom_range(496, 511));
                    c.ty = 9'($urandom_range(496, 511));
                end else if (mode == 8) begin
                    c.lx = 9'($urandom_range(480, 511));
                    c.w  = 10'($urandom_range(32, 512));
                    c.h  = 10'($urandom_range(1, 6));
                end else begin
                    c.ty = 9'($urandom_range(480, 511));
                    c.w  = 10'($urandom_range(1, 6));
                    c.h  = 10'($urandom_range(32, 512));
                end
                if ($urandom_range(0, 5) == 0)
                    c.opacity = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                if (c.w != 0 && c.h != 0) begin
                    have_rect = 1'b1;
                    rect_x = int'(c.lx);
                    rect_y = int'(c.ty);
                    rect_w = (int'(c.lx) + int'(c.w) > FW) ? FW - int'(c.lx) : int'(c.w);
                    rect_h = (int'(c.ty) + int'(c.h) > FH) ? FH - int'(c.ty) : int'(c.h);
                end
            end else if (c.op == OP_READ && have_rect && $urandom_range(0, 2) != 0) begin
                c.lx = 9'(rect_x + int'($urandom_range(0, rect_w - 1)));
                c.ty = 9'(rect_y + int'($urandom_range(0, rect_h - 1)));
            end

            offer_request(c, 1'b0, none);
        end
        i_s_axis_tvalid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
